/* hdl/fupd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_pkg
// Shared types, character codes and helper functions for the file URI path
// decoder: phase and escape codes, channel payloads, hex helpers.
// ----------------------------------------------------------------------------
package fupd_pkg;

  // characters the decoder looks for
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  // number of result bytes one input byte can cause
  localparam int MaxRes = 5;

  // parser phase
  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_SLASH1 = 3'd1,
    PH_SLASH2 = 3'd2,
    PH_AUTH   = 3'd3,
    PH_PATH   = 3'd4
  } phase_t;

  // percent escape progress
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_PCT   = 2'd1;
  localparam logic [1:0] ESC_DIGIT = 2'd2;

  // input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uri_item_t;

  // output transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       no_path;
  } path_item_t;

  // parser state carried between input bytes
  typedef struct packed {
    phase_t     phase;
    logic [2:0] prefix_count;
    logic [1:0] esc;
    logic [7:0] held;
  } state_t;

  // results of one input byte
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   marker;
    logic                   last;
    logic                   no_path;
  } step_res_t;

  // outcome of feeding one byte to the percent decoder
  typedef struct packed {
    logic [1:0]      esc;
    logic [7:0]      held;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } dec_t;

  // characters of the "file:" prefix
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;  // 'f'
      3'd1:    c = 8'h69;  // 'i'
      3'd2:    c = 8'h6C;  // 'l'
      3'd3:    c = 8'h65;  // 'e'
      default: c = 8'h3A;  // ':'
    endcase
    return c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  // one byte through the percent decoder; a broken escape is flushed and
  // the byte that broke it is looked at again as a fresh start
  function automatic dec_t decode_byte(input logic [1:0] esc, input logic [7:0] held,
                                       input logic [7:0] b);
    dec_t d;
    logic redo;
    d       = '0;
    d.esc   = esc;
    d.held  = held;
    redo    = 1'b0;
    case (esc)
      ESC_NONE: begin
        redo = 1'b1;
      end
      ESC_PCT: begin
        if (is_hex(b)) begin
          d.held = b;
          d.esc  = ESC_DIGIT;
        end else begin
          d.bytes[0] = CH_PCT;
          d.cnt      = 2'd1;
          d.esc      = ESC_NONE;
          redo       = 1'b1;
        end
      end
      default: begin
        if (is_hex(b) && is_hex(held)) begin
          d.bytes[0] = {hex_val(held), hex_val(b)};
          d.cnt      = 2'd1;
        end else begin
          d.bytes[0] = CH_PCT;
          d.bytes[1] = held;
          d.cnt      = 2'd2;
          redo       = 1'b1;
        end
        d.esc  = ESC_NONE;
        d.held = 8'h00;
      end
    endcase
    if (redo) begin
      if (b == CH_PCT) begin
        d.esc = ESC_PCT;
      end else begin
        d.bytes[d.cnt] = b;
        d.cnt          = d.cnt + 2'd1;
      end
    end
    return d;
  endfunction

  // append one byte to a result list
  function automatic step_res_t push_byte(input step_res_t r, input logic [7:0] b);
    step_res_t o;
    o = r;
    if (o.cnt < 3'(MaxRes)) begin
      o.bytes[o.cnt] = b;
      o.cnt          = o.cnt + 3'd1;
    end
    return o;
  endfunction

  // append the bytes of a decoder outcome
  function automatic step_res_t push_dec(input step_res_t r, input dec_t d);
    step_res_t o;
    o = r;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(d.cnt)) begin
        o = push_byte(o, d.bytes[k]);
      end
    end
    return o;
  endfunction

endpackage : fupd_pkg
`default_nettype wire

/* hdl/fupd_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_step
// Combinational step of the decoder: from the current state and one URI byte,
// the next state and the list of path bytes that byte releases.
// ----------------------------------------------------------------------------
module fupd_step (
  input  fupd_pkg::state_t    st,
  input  fupd_pkg::uri_item_t item,
  output fupd_pkg::state_t    nxt,
  output fupd_pkg::step_res_t res
);
  import fupd_pkg::*;

  logic [7:0] b;
  logic [2:0] pc;
  dec_t       d_b;
  dec_t       d_s;
  dec_t       d_sb;

  assign b  = item.in_byte;
  // out-of-range counts behave as a full match of "file"
  assign pc = (st.prefix_count > 3'd4) ? 3'd4 : st.prefix_count;

  // decoder outcomes: the byte alone, and a held slash followed by the byte
  assign d_b  = decode_byte(st.esc, st.held, b);
  assign d_s  = decode_byte(st.esc, st.held, CH_SLASH);
  assign d_sb = decode_byte(d_s.esc, d_s.held, b);

  always_comb begin
    step_res_t r;
    state_t    n;
    logic      empty_path;
    n              = st;
    n.prefix_count = pc;
    r              = '0;
    empty_path     = 1'b0;

    // phase handling for this byte
    case (st.phase)
      PH_PREFIX: begin
        if (b == prefix_char(pc)) begin
          if (pc == 3'd4) begin
            n.prefix_count = 3'd0;
            n.phase        = PH_SLASH1;
          end else begin
            n.prefix_count = pc + 3'd1;
          end
        end else if (pc == 3'd0) begin
          if (b == CH_SLASH) begin
            n.phase = PH_SLASH2;
          end else begin
            n.phase = PH_PATH;
            r       = push_dec(r, d_b);
            n.esc   = d_b.esc;
            n.held  = d_b.held;
          end
        end else begin
          // partial prefix goes out literally
          for (int k = 0; k < 4; k++) begin
            if (k < int'(pc)) begin
              r = push_byte(r, prefix_char(3'(k)));
            end
          end
          n.prefix_count = 3'd0;
          n.phase        = PH_PATH;
          r              = push_dec(r, d_b);
          n.esc          = d_b.esc;
          n.held         = d_b.held;
        end
      end
      PH_SLASH1: begin
        if (b == CH_SLASH) begin
          n.phase = PH_SLASH2;
        end else begin
          n.phase = PH_PATH;
          r       = push_dec(r, d_b);
          n.esc   = d_b.esc;
          n.held  = d_b.held;
        end
      end
      PH_SLASH2: begin
        if (b == CH_SLASH) begin
          n.phase = PH_AUTH;
        end else begin
          // single slash is a path byte
          n.phase = PH_PATH;
          r       = push_dec(r, d_s);
          r       = push_dec(r, d_sb);
          n.esc   = d_sb.esc;
          n.held  = d_sb.held;
        end
      end
      PH_AUTH: begin
        if (b == CH_SLASH) begin
          n.phase = PH_PATH;
          r       = push_dec(r, d_b);
          n.esc   = d_b.esc;
          n.held  = d_b.held;
        end
      end
      default: begin
        n.phase = PH_PATH;
        r       = push_dec(r, d_b);
        n.esc   = d_b.esc;
        n.held  = d_b.held;
      end
    endcase

    // end of uri: flush held bytes, add an end marker if nothing came out
    if (item.in_last) begin
      case (n.phase)
        PH_PREFIX: begin
          for (int k = 0; k < 4; k++) begin
            if (k < int'(n.prefix_count)) begin
              r = push_byte(r, prefix_char(3'(k)));
            end
          end
        end
        PH_SLASH2: r = push_byte(r, CH_SLASH);
        PH_AUTH:   empty_path = 1'b1;
        default:   ;
      endcase
      if (n.esc == ESC_PCT) begin
        r = push_byte(r, CH_PCT);
      end else if (n.esc == ESC_DIGIT) begin
        r = push_byte(r, CH_PCT);
        r = push_byte(r, n.held);
      end
      r.last = 1'b1;
      if (r.cnt == 3'd0) begin
        r.marker  = 1'b1;
        r.cnt     = 3'd1;
        r.no_path = empty_path;
      end
      n.phase        = PH_PREFIX;
      n.prefix_count = 3'd0;
      n.esc          = ESC_NONE;
      n.held         = 8'h00;
    end

    nxt = n;
    res = r;
  end

endmodule : fupd_step
`default_nettype wire

/* hdl/file_uri_path_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// file_uri_path_decoder
// Streaming file URI to path decoder: strips "file:" and the authority,
// percent-decodes the path, one URI byte per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   uri channel: one URI byte per transfer, in_last on the final byte.
//   path channel: one decoded byte per transfer; out_last on the final result
//   of a URI. A URI with no output bytes yields one end marker with
//   byte_valid low (no_path high if the URI ended inside the authority).
//   Results of a byte appear the cycle after its transfer.
//   Throughput: one URI byte per cycle while path_stall is low and each byte
//   releases at most one path byte; a byte that releases k bytes (up to 5:
//   prefix replay, broken escape, end-of-URI flush) fills the result buffer,
//   and the uri channel stalls until the buffer's last entry leaves.
//   A new byte is taken in the same cycle the last buffered result transfers.
//   When path_stall is high the current result holds and uri_stall rises.
//   Reset (rst, synchronous) empties the result buffer and returns the parser
//   to prefix matching.
// ----------------------------------------------------------------------------
module file_uri_path_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 uri_valid,
  output logic                 uri_stall,
  input  fupd_pkg::uri_item_t  uri,
  output logic                 path_valid,
  input  logic                 path_stall,
  output fupd_pkg::path_item_t path
);
  import fupd_pkg::*;

  state_t                 st;
  state_t                 st_next;
  step_res_t              res;
  logic [MaxRes-1:0][7:0] buf_bytes;
  logic [2:0]             buf_idx;
  logic [2:0]             buf_rem;
  logic                   buf_marker;
  logic                   buf_last;
  logic                   buf_nopath;
  logic                   in_xfer;
  logic                   out_xfer;

  // per-byte parsing and decoding
  fupd_step u_step (
    .st   (st),
    .item (uri),
    .nxt  (st_next),
    .res  (res)
  );

  // handshake: take a byte once the buffer is empty or emptying
  assign path_valid = (buf_rem != 3'd0);
  assign out_xfer   = path_valid && !path_stall;
  assign uri_stall  = (buf_rem > 3'd1) || ((buf_rem == 3'd1) && path_stall);
  assign in_xfer    = uri_valid && !uri_stall;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_PREFIX;
      st.prefix_count <= 3'd0;
      st.esc          <= ESC_NONE;
      st.held         <= 8'h00;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_rem <= 3'd0;
      buf_idx <= 3'd0;
    end else if (in_xfer) begin
      buf_rem <= res.cnt;
      buf_idx <= 3'd0;
    end else if (out_xfer) begin
      buf_rem <= buf_rem - 3'd1;
      buf_idx <= buf_idx + 3'd1;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_bytes  <= res.bytes;
      buf_marker <= res.marker;
      buf_last   <= res.last;
      buf_nopath <= res.no_path;
    end
  end

  // output transfer payload
  assign path.out_byte   = buf_bytes[buf_idx];
  assign path.byte_valid = !buf_marker;
  assign path.out_last   = buf_last && (buf_rem == 3'd1);
  assign path.no_path    = buf_marker && buf_nopath;

endmodule : file_uri_path_decoder
`default_nettype wire

/* hdl/fupd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_checker
// Port-level checks for the file URI path decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fupd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 uri_stall,
  input logic                 path_valid,
  input logic                 path_stall,
  input fupd_pkg::path_item_t path
);
  import fupd_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    path_valid && path_stall |=> path_valid && $stable(path))
    else $error("stalled result changed");

  // the uri side stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    uri_stall |-> path_valid)
    else $error("input stalled with empty result buffer");

  // an end marker always closes a path
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    path_valid && !path.byte_valid |-> path.out_last)
    else $error("end marker without out_last");

  // empty-path flag rides only on an end marker
  a_nopath: assert property (@(posedge clk) disable iff (rst)
    path_valid && path.no_path |-> !path.byte_valid && path.out_last)
    else $error("no_path on a data byte");

  // reset empties the result buffer
  a_reset: assert property (@(posedge clk) rst |=> !path_valid)
    else $error("result pending after reset");

endmodule : fupd_checker

bind file_uri_path_decoder fupd_checker u_fupd_checker (.*);
`default_nettype wire

/* sim/path_decode_monitor.sv */
// ----------------------------------------------------------------------------
// path_decode_monitor
// Watches both channels of the file URI path decoder. It predicts the path
// results of every accepted URI byte and compares each path transfer, field
// by field, with the oldest expected result.
// ----------------------------------------------------------------------------
module path_decode_monitor
  import fupd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       uri_valid,
  input  logic       uri_stall,
  input  uri_item_t  uri,
  input  logic       path_valid,
  input  logic       path_stall,
  input  path_item_t path,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // text of the scheme prefix
  localparam logic [7:0] SchemeText [5] = '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A};

  // predicted parser state
  phase_t     ph;
  logic [2:0] matched;
  logic [1:0] esc;
  logic [7:0] held_digit;

  // bytes released by the current URI byte, and results still to arrive
  logic [7:0] step_bytes[$];
  path_item_t path_expect[$];

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return int'(c) - 'h30;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return int'(c) - 'h61 + 10;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return int'(c) - 'h41 + 10;
    end
    return -1;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (step_bytes.size() < MaxRes) begin
      step_bytes.insert(step_bytes.size(), b);
    end
  endfunction

  // percent decoding; a byte that breaks an escape is looked at again
  function automatic void pct_decode(input logic [7:0] b);
    bit again;
    int lo;
    int hi;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (esc)
        ESC_NONE: begin
          if (b == CH_PCT) begin
            esc = ESC_PCT;
          end else begin
            emit(b);
          end
        end
        ESC_PCT: begin
          if (hex_digit(b) >= 0) begin
            held_digit = b;
            esc        = ESC_DIGIT;
          end else begin
            emit(CH_PCT);
            esc   = ESC_NONE;
            again = 1'b1;
          end
        end
        default: begin
          lo = hex_digit(b);
          hi = hex_digit(held_digit);
          if (lo >= 0 && hi >= 0) begin
            emit(8'((hi << 4) | lo));
          end else begin
            emit(CH_PCT);
            emit(held_digit);
            again = 1'b1;
          end
          esc        = ESC_NONE;
          held_digit = 8'h00;
        end
      endcase
    end
  endfunction

  // start of the text after the scheme: a slash may open an authority
  function automatic void first_slash(input logic [7:0] b);
    if (b == CH_SLASH) begin
      ph = PH_SLASH2;
    end else begin
      ph = PH_PATH;
      pct_decode(b);
    end
  endfunction

  function automatic void clear_parser();
    ph         = PH_PREFIX;
    matched    = 3'd0;
    esc        = ESC_NONE;
    held_digit = 8'h00;
  endfunction

  // expected path results of one accepted URI byte
  function automatic void predict_path(input uri_item_t item);
    logic [7:0] b;
    logic       fin;
    bit         authority_end;
    int         n;
    b             = item.in_byte;
    fin           = item.in_last;
    authority_end = 1'b0;
    step_bytes.delete();
    if (matched > 3'd4) begin
      matched = 3'd4;
    end
    case (ph)
      PH_PREFIX: begin
        if (b == SchemeText[matched]) begin
          matched = matched + 3'd1;
          if (matched == 3'd5) begin
            matched = 3'd0;
            ph      = PH_SLASH1;
          end
        end else if (matched == 3'd0) begin
          first_slash(b);
        end else begin
          for (int k = 0; k < int'(matched); k++) begin
            emit(SchemeText[k]);
          end
          matched = 3'd0;
          ph      = PH_PATH;
          pct_decode(b);
        end
      end
      PH_SLASH1: begin
        first_slash(b);
      end
      PH_SLASH2: begin
        if (b == CH_SLASH) begin
          ph = PH_AUTH;
        end else begin
          ph = PH_PATH;
          pct_decode(CH_SLASH);
          pct_decode(b);
        end
      end
      PH_AUTH: begin
        if (b == CH_SLASH) begin
          ph = PH_PATH;
          pct_decode(b);
        end
      end
      default: begin
        ph = PH_PATH;
        pct_decode(b);
      end
    endcase

    // end of URI: flush whatever is held
    if (fin) begin
      if (ph == PH_PREFIX) begin
        for (int k = 0; k < int'(matched); k++) begin
          emit(SchemeText[k]);
        end
      end else if (ph == PH_SLASH2) begin
        emit(CH_SLASH);
      end else if (ph == PH_AUTH) begin
        authority_end = 1'b1;
      end
      if (esc == ESC_PCT) begin
        emit(CH_PCT);
      end else if (esc == ESC_DIGIT) begin
        emit(CH_PCT);
        emit(held_digit);
      end
    end

    n = step_bytes.size();
    for (int k = 0; k < n; k++) begin
      path_expect.insert(path_expect.size(),
                         path_item_t'{out_byte: step_bytes[k], byte_valid: 1'b1,
                                      out_last: fin && k == n - 1, no_path: 1'b0});
    end
    if (fin && n == 0) begin
      path_expect.insert(path_expect.size(),
                         path_item_t'{out_byte: 8'h00, byte_valid: 1'b0,
                                      out_last: 1'b1, no_path: authority_end});
    end
    if (fin) begin
      clear_parser();
    end
  endfunction

  // one path transfer against the oldest expected result
  function automatic void check_path(input path_item_t got);
    path_item_t want;
    if (path_expect.size() == 0) begin
      mismatches++;
      $display("%0t: path transfer with no result pending: expected none, got byte %02h",
               $time, got.out_byte, " valid %b last %b no_path %b",
               got.byte_valid, got.out_last, got.no_path);
      return;
    end
    want = path_expect.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.out_last !== want.out_last || got.no_path !== want.no_path) begin
      mismatches++;
      $display("%0t: path mismatch: expected byte %02h valid %b last %b no_path %b,",
               $time, want.out_byte, want.byte_valid, want.out_last, want.no_path,
               " got byte %02h valid %b last %b no_path %b",
               got.out_byte, got.byte_valid, got.out_last, got.no_path);
    end
  endfunction

  // results leave only after their byte is registered, so check before predicting
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      path_expect.delete();
    end else begin
      if (path_valid && !path_stall) begin
        check_path(path);
      end
      if (uri_valid && !uri_stall) begin
        predict_path(uri);
      end
    end
    outstanding = path_expect.size();
  end

endmodule : path_decode_monitor

/* sim/file_uri_path_decoder_tb.sv */
// ----------------------------------------------------------------------------
// file_uri_path_decoder_tb
// Drives URIs into the file URI path decoder: a directed set of scheme,
// authority and escape corner cases, then random URIs of mixed shapes, with
// random gaps on the URI side and random stalls on the path side. The
// monitor beside the block predicts and checks every path transfer.
// ----------------------------------------------------------------------------
module file_uri_path_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fupd_pkg::*;

  localparam int RandomBytes = 400;
  localparam int IdleLimit   = 2000;
  localparam int TailCycles  = 20;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       uri_valid  = 1'b0;
  uri_item_t  uri        = '0;
  logic       path_stall = 1'b0;
  logic       uri_stall;
  logic       path_valid;
  path_item_t path;

  int         mismatches;
  int         outstanding;
  int         gap_max   = 3;
  int         stall_max = 3;
  logic [7:0] uri_text[$];

  string      corner_uris[] = '{"file%", "//h", "/a", "file:", "%4g", "file:/x%2f%%41"};

  file_uri_path_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .uri_valid  (uri_valid),
    .uri_stall  (uri_stall),
    .uri        (uri),
    .path_valid (path_valid),
    .path_stall (path_stall),
    .path       (path)
  );

  path_decode_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .uri_valid   (uri_valid),
    .uri_stall   (uri_stall),
    .uri         (uri),
    .path_valid  (path_valid),
    .path_stall  (path_stall),
    .path        (path),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // idle regime: sometimes none, sometimes light, most often the full range
  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 12;
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] rand_host_char();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return 8'h2E;
      2:       return CH_PCT;
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // add one character at the end of the URI text
  function automatic void put_char(input logic [7:0] c);
    uri_text.insert(uri_text.size(), c);
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endfunction

  // path text: plain characters, good escapes, broken escapes, raw bytes
  function automatic void append_path(input int pieces);
    for (int i = 0; i < pieces; i++) begin
      case ($urandom_range(0, 9))
        5, 6: begin
          put_char(CH_PCT);
          put_char(rand_hex());
          put_char(rand_hex());
        end
        7: begin
          put_char(CH_PCT);
          put_char(8'($urandom_range(0, 255)));
        end
        8: begin
          put_char(CH_PCT);
          put_char(rand_hex());
          put_char(8'($urandom_range(0, 255)));
        end
        9: begin
          put_char(8'($urandom_range(0, 255)));
        end
        default: begin
          put_char(8'($urandom_range(8'h21, 8'h7E)));
        end
      endcase
    end
  endfunction

  function automatic void append_authority();
    int hn;
    hn = $urandom_range(0, 4);
    for (int i = 0; i < hn; i++) begin
      put_char(rand_host_char());
    end
    // now and then the authority runs to the end with no slash
    if ($urandom_range(0, 5) != 0) begin
      put_char(CH_SLASH);
      append_path($urandom_range(0, 5));
    end
  endfunction

  // one random URI, mostly well formed, some broken and some noise
  function automatic void make_uri();
    string scheme;
    int    k;
    scheme = "file:";
    uri_text.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        append_text("file://");
        append_authority();
      end
      4: begin
        append_text("file:");
        if ($urandom_range(0, 1)) begin
          put_char(CH_SLASH);
        end
        append_path($urandom_range(0, 5));
      end
      5: begin
        append_text("//");
        append_authority();
      end
      6: begin
        put_char(CH_SLASH);
        append_path($urandom_range(0, 5));
      end
      7: begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          put_char(scheme[i]);
        end
        append_path($urandom_range(0, 4));
      end
      8: begin
        append_path($urandom_range(1, 6));
      end
      default: begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          put_char(8'($urandom_range(0, 255)));
        end
      end
    endcase
    if (uri_text.size() == 0) begin
      put_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // one URI byte: optional gap, then hold until the transfer
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      uri_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    uri_valid <= 1'b1;
    uri       <= uri_item_t'{in_byte: b, in_last: fin};
    do @(posedge clk); while (uri_stall);
  endtask

  task automatic send_uri();
    for (int i = 0; i < uri_text.size(); i++) begin
      send_byte(uri_text[i], i == uri_text.size() - 1);
    end
  endtask

  // hold off the URI side until every pending result has come out
  task automatic drain();
    uri_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // path side: random stall ahead of each result
  initial begin : path_sink
    int hold;
    wait (!rst);
    forever begin
      hold = $urandom_range(0, stall_max);
      if (hold > 0) begin
        path_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        path_stall <= 1'b0;
      end
      do @(posedge clk); while (!(path_valid && !path_stall));
    end
  end

  // ends the run when neither channel has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (!rst);
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((uri_valid && !uri_stall) || (path_valid && !path_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int uris;
    sent = 0;
    uris = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    foreach (corner_uris[i]) begin
      uri_text.delete();
      append_text(corner_uris[i]);
      send_uri();
    end
    // extreme byte values inside a path, with a mixed-case escape
    uri_text.delete();
    put_char(8'hFF);
    append_text("%eA");
    put_char(8'h00);
    send_uri();
    drain();

    // random URIs with changing idle regimes
    while (sent < RandomBytes) begin
      gap_max   = pick_idle();
      stall_max = pick_idle();
      make_uri();
      send_uri();
      sent += uri_text.size();
      uris++;
      if (uris % 25 == 0) begin
        drain();
      end
    end
    drain();
    repeat (TailCycles) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : file_uri_path_decoder_tb
